// ===== design/mbrc_pkg.sv =====
`default_nettype none

package mbrc_pkg;

   localparam int MAX_FRAME_DEFAULT = 1024;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0]  WANT_COUNT = 8'd4;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SHORT     = 2'd1,
      STATUS_CRC_ERROR = 2'd2,
      STATUS_BAD_COUNT = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] integer_word;
      logic [15:0] fraction_word;
   } rsp_type;

   // one byte through the reflected CRC-16/Modbus shift register
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/mbrc_frame_check.sv =====
`default_nettype none

module mbrc_frame_check #(
   parameter int MAX_FRAME = mbrc_pkg::MAX_FRAME_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire mbrc_pkg::req_type item,
   output logic                  result_valid,
   output mbrc_pkg::rsp_type     result
);

   localparam int CNT_W = $clog2(MAX_FRAME + 1);

   logic [15:0]      crc_ff, crc_in;
   logic [CNT_W-1:0] seen_ff, seen_in;
   logic [7:0]       delay0_ff, delay0_in;
   logic [7:0]       delay1_ff, delay1_in;
   logic [7:0]       count_ff, count_in;
   logic [15:0]      integer_ff, integer_in;
   logic [15:0]      fraction_ff, fraction_in;

   logic [15:0] crc_cur;
   logic [7:0]  count_cur;
   logic [15:0] integer_cur;
   logic [15:0] fraction_cur;

   always_comb begin
      crc_cur      = (seen_ff >= CNT_W'(2)) ? mbrc_pkg::crc_feed(crc_ff, delay1_ff) : crc_ff;
      count_cur    = count_ff;
      integer_cur  = integer_ff;
      fraction_cur = fraction_ff;
      case (seen_ff)
         CNT_W'(2): count_cur          = item.data_byte;
         CNT_W'(3): integer_cur[15:8]  = item.data_byte;
         CNT_W'(4): integer_cur[7:0]   = item.data_byte;
         CNT_W'(5): fraction_cur[15:8] = item.data_byte;
         CNT_W'(6): fraction_cur[7:0]  = item.data_byte;
         default: ;
      endcase
   end

   // check order: length, then CRC (low byte first), then byte count
   always_comb begin
      result_valid         = advance && item.last_byte;
      result.integer_word  = 16'h0000;
      result.fraction_word = 16'h0000;
      if (seen_ff < CNT_W'(7)) begin
         result.status = mbrc_pkg::STATUS_SHORT;
      end else if (crc_cur[7:0] != delay0_ff || crc_cur[15:8] != item.data_byte) begin
         result.status = mbrc_pkg::STATUS_CRC_ERROR;
      end else if (count_cur != mbrc_pkg::WANT_COUNT) begin
         result.status = mbrc_pkg::STATUS_BAD_COUNT;
      end else begin
         result.status        = mbrc_pkg::STATUS_OK;
         result.integer_word  = integer_cur;
         result.fraction_word = fraction_cur;
      end
   end

   always_comb begin
      crc_in      = crc_ff;
      seen_in     = seen_ff;
      delay0_in   = delay0_ff;
      delay1_in   = delay1_ff;
      count_in    = count_ff;
      integer_in  = integer_ff;
      fraction_in = fraction_ff;
      if (advance) begin
         if (item.last_byte) begin
            crc_in  = mbrc_pkg::CRC_INIT;
            seen_in = '0;
         end else begin
            crc_in      = crc_cur;
            delay1_in   = delay0_ff;
            delay0_in   = item.data_byte;
            count_in    = count_cur;
            integer_in  = integer_cur;
            fraction_in = fraction_cur;
            if (seen_ff < CNT_W'(MAX_FRAME)) begin
               seen_in = seen_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= mbrc_pkg::CRC_INIT;
         seen_ff <= '0;
      end else begin
         crc_ff  <= crc_in;
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      delay0_ff   <= delay0_in;
      delay1_ff   <= delay1_in;
      count_ff    <= count_in;
      integer_ff  <= integer_in;
      fraction_ff <= fraction_in;
   end

endmodule

`default_nettype wire

// ===== design/modbus_response_checker_unit.sv =====
// Modbus RTU reply checker.
// Request channel (req_valid / req_stall / req_data): one reply byte per word,
// with last_byte set on the final byte of the reply.
// Response channel (rsp_valid / rsp_stall / rsp_data): one word per reply,
// issued for the marked byte: status, integer word and fraction word
// (both zero unless status is ok). Unmarked bytes produce no word.
// A word moves at a rising edge where valid is high and stall is low.
// Throughput: one byte per cycle, sustained, while the receiver keeps up.
// A marked byte passes through the input register, then the CRC/check logic
// into the result register, before it shows on rsp_valid.
// The per-byte CRC update is one combinational pass between those registers.
// Reset (synchronous, active high) drops any held words and restarts the
// frame: CRC back to 0xFFFF and the byte counter to zero.
// When the receiver stalls, the result register holds its word; the input
// register then fills and req_stall rises until the result is taken.
// A reply that reaches MAX_FRAME bytes saturates the counter; the CRC still
// covers every byte.
`default_nettype none

module modbus_response_checker_unit #(
   parameter int MAX_FRAME = mbrc_pkg::MAX_FRAME_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mbrc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mbrc_pkg::rsp_type      rsp_data
);

   logic              in_valid_ff, in_valid_in;
   mbrc_pkg::req_type in_word_ff, in_word_in;
   logic              out_valid_ff, out_valid_in;
   mbrc_pkg::rsp_type out_word_ff, out_word_in;

   logic              out_free;
   logic              advance;
   logic              result_valid;
   mbrc_pkg::rsp_type result;

   // result register can take a new word when empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   // hold the input register only while its byte cannot advance
   assign req_stall = in_valid_ff && !out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_word_in  = req_data;
      end
   end

   mbrc_frame_check #(
      .MAX_FRAME(MAX_FRAME)
   ) u_frame_check (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (in_word_ff),
      .result_valid(result_valid),
      .result      (result)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (out_free) begin
         out_valid_in = result_valid;
         out_word_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

`ifndef SYNTHESIS
   // a held input byte stays put until the result side frees up
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> in_valid_ff && $stable(in_word_ff))
      else $error("input register changed while stalled");

   // back-pressure only comes from a blocked result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (out_valid_ff && rsp_stall))
      else $error("req_stall without a blocked result");

   // failed replies carry zero words
   a_zero_words: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_word_ff.status != mbrc_pkg::STATUS_OK)
         |-> (out_word_ff.integer_word == 16'h0000 && out_word_ff.fraction_word == 16'h0000))
      else $error("nonzero words on a failed reply");
`endif

endmodule

`default_nettype wire

// ===== verif/modbus_reply_checker.sv =====
`timescale 1ns / 100ps

module modbus_reply_checker #(
   parameter int FRAME_CAP = mbrc_pkg::MAX_FRAME_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire mbrc_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire mbrc_pkg::rsp_type rsp_data,
   output int                     pending_replies,
   output int                     mismatch_total
);

   // frame state of the predicted checker
   logic [15:0] crc_acc;
   logic [7:0]  newest_byte;
   logic [7:0]  older_byte;
   int          seen_count;
   logic [7:0]  count_byte;
   logic [15:0] integer_acc;
   logic [15:0] fraction_acc;

   mbrc_pkg::rsp_type expected_replies[$];
   mbrc_pkg::rsp_type oldest_reply;
   int                mismatch_count = 0;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      repeat (8) begin
         c = c[0] ? ((c >> 1) ^ mbrc_pkg::CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   task automatic restart_frame();
      crc_acc      = mbrc_pkg::CRC_INIT;
      newest_byte  = '0;
      older_byte   = '0;
      seen_count   = 0;
      count_byte   = '0;
      integer_acc  = '0;
      fraction_acc = '0;
   endtask

   // Fold one byte into the frame state; queue a reply word on the marked byte.
   task automatic absorb_byte(input mbrc_pkg::req_type w);
      mbrc_pkg::rsp_type r;
      if (seen_count >= 2) begin
         crc_acc = crc_step(crc_acc, older_byte);
      end
      case (seen_count)
         2: count_byte = w.data_byte;
         3: integer_acc[15:8] = w.data_byte;
         4: integer_acc[7:0] = w.data_byte;
         5: fraction_acc[15:8] = w.data_byte;
         6: fraction_acc[7:0] = w.data_byte;
         default: ;
      endcase
      if (!w.last_byte) begin
         older_byte  = newest_byte;
         newest_byte = w.data_byte;
         if (seen_count < FRAME_CAP) begin
            seen_count++;
         end
      end else begin
         r = '0;
         if (seen_count + 1 < 8) begin
            r.status = mbrc_pkg::STATUS_SHORT;
         end else if (crc_acc[7:0] != newest_byte || crc_acc[15:8] != w.data_byte) begin
            r.status = mbrc_pkg::STATUS_CRC_ERROR;
         end else if (count_byte != mbrc_pkg::WANT_COUNT) begin
            r.status = mbrc_pkg::STATUS_BAD_COUNT;
         end else begin
            r.status        = mbrc_pkg::STATUS_OK;
            r.integer_word  = integer_acc;
            r.fraction_word = fraction_acc;
         end
         expected_replies.push_back(r);
         restart_frame();
      end
   endtask

   task automatic report(input string what, input mbrc_pkg::rsp_type want,
                         input mbrc_pkg::rsp_type got);
      if (mismatch_count < 10) begin
         $display("%0t: %s: expected status %0d int %h frac %h, got status %0d int %h frac %h",
                  $time, what, want.status, want.integer_word, want.fraction_word,
                  got.status, got.integer_word, got.fraction_word);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_frame();
         expected_replies.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               report("reply word with nothing expected", '0, rsp_data);
            end else begin
               oldest_reply = expected_replies.pop_front();
               if (rsp_data.status != oldest_reply.status) begin
                  report("status", oldest_reply, rsp_data);
               end
               if (rsp_data.integer_word != oldest_reply.integer_word) begin
                  report("integer_word", oldest_reply, rsp_data);
               end
               if (rsp_data.fraction_word != oldest_reply.fraction_word) begin
                  report("fraction_word", oldest_reply, rsp_data);
               end
            end
         end
         if (req_valid && !req_stall) begin
            absorb_byte(req_data);
         end
      end
      pending_replies <= expected_replies.size();
      mismatch_total  <= mismatch_count;
   end

endmodule

// ===== verif/tb_modbus_response_checker_unit.sv =====
`timescale 1ns / 100ps

module tb_modbus_response_checker_unit;

   // Small frame cap so that long replies saturate the byte counter often.
   localparam int FRAME_CAP    = 16;
   localparam int RUN_LIMIT    = 400000;
   localparam int TARGET_WORDS = 1850;
   localparam int LONG_HOLD    = 400;
   localparam int HOLD_AFTER   = 300;
   localparam int DRAIN_CYCLES = 16;

   // how the two CRC bytes of a built frame are appended
   typedef enum int {
      CRC_GOOD,
      CRC_FLIPPED,
      CRC_SWAPPED,
      CRC_NONE
   } crc_mode_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   mbrc_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   mbrc_pkg::rsp_type rsp_data;

   int      pending_replies;
   int      mismatch_total;
   int      cycle_count    = 0;
   int      words_sent     = 0;
   bit      long_hold_done = 1'b0;

   logic [7:0]        frame_buf[$];
   mbrc_pkg::req_type stim_q[$];

   modbus_response_checker_unit #(
      .MAX_FRAME(FRAME_CAP)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   modbus_reply_checker #(
      .FRAME_CAP(FRAME_CAP)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .pending_replies(pending_replies),
      .mismatch_total (mismatch_total)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // CRC-16/Modbus over the frame being built, used to make well-formed replies.
   function automatic logic [15:0] modbus_crc();
      logic [15:0] c;
      c = mbrc_pkg::CRC_INIT;
      foreach (frame_buf[i]) begin
         c = c ^ {8'h00, frame_buf[i]};
         repeat (8) begin
            c = c[0] ? ((c >> 1) ^ mbrc_pkg::CRC_POLY) : (c >> 1);
         end
      end
      return c;
   endfunction

   // Start a reply: slave address, function code (mostly read holding registers), count.
   task automatic start_reply(input logic [7:0] count);
      frame_buf.delete();
      frame_buf.push_back(8'($urandom_range(0, 255)));
      frame_buf.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'h03);
      frame_buf.push_back(count);
   endtask

   // Append payload bytes, biased toward the all-zero and all-one extremes.
   task automatic add_random_bytes(input int n);
      repeat (n) begin
         if ($urandom_range(0, 4) == 0) begin
            frame_buf.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
         end else begin
            frame_buf.push_back(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Append the CRC (low byte first, unless swapped or dropped) and queue the frame
   // as words, marking the final one.
   task automatic emit_frame(input crc_mode_type mode);
      logic [15:0]       crc;
      logic [3:0]        flip;
      mbrc_pkg::req_type w;
      crc = modbus_crc();
      case (mode)
         CRC_FLIPPED: begin
            flip      = 4'($urandom_range(0, 15));
            crc[flip] = ~crc[flip];
         end
         CRC_SWAPPED: begin
            crc = {crc[7:0], crc[15:8]};
         end
         default: ;
      endcase
      if (mode != CRC_NONE) begin
         frame_buf.push_back(crc[7:0]);
         frame_buf.push_back(crc[15:8]);
      end
      foreach (frame_buf[i]) begin
         w.data_byte = frame_buf[i];
         w.last_byte = (i == frame_buf.size() - 1);
         stim_q.push_back(w);
      end
      frame_buf.delete();
   endtask

   // Receiver: stall on segments of random style, with one long hold-off once the
   // sender is well under way so the block backs up and stalls its input.
   initial begin : receiver
      int mode;
      int span;
      int tick;
      tick = 0;
      forever begin
         if (!long_hold_done && words_sent >= HOLD_AFTER) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_done = 1'b1;
         end
         mode = $urandom_range(0, 4);
         span = $urandom_range(10, 120);
         repeat (span) begin
            case (mode)
               0, 1:    rsp_stall <= 1'b0;
               2:       rsp_stall <= 1'($urandom_range(0, 1));
               3:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (tick % 4 == 0);
            endcase
            tick++;
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int kind;
      int idx;
      int burst;
      int gap;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;

      // Directed: full good reply at the extremes, a lone marked byte, the longest
      // short reply, and a minimum-length reply with its CRC bytes in the wrong order.
      frame_buf = '{8'hFF, 8'h03, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00};
      emit_frame(CRC_GOOD);
      frame_buf = '{8'h00};
      emit_frame(CRC_NONE);
      frame_buf = '{8'h01, 8'h03, 8'h04, 8'hAA, 8'h55, 8'hFF, 8'h00};
      emit_frame(CRC_NONE);
      frame_buf = '{8'h01, 8'h03, 8'h04, 8'h12, 8'h34, 8'h56};
      emit_frame(CRC_SWAPPED);

      // Random: mostly well-formed replies, mixed with broken ones and noise.
      while (stim_q.size() < TARGET_WORDS) begin
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            start_reply(mbrc_pkg::WANT_COUNT);
            add_random_bytes(4);
            emit_frame(CRC_GOOD);
         end else if (kind < 65) begin
            start_reply(mbrc_pkg::WANT_COUNT);
            add_random_bytes(4);
            emit_frame($urandom_range(0, 1) ? CRC_FLIPPED : CRC_SWAPPED);
         end else if (kind < 75) begin
            // odd payload size, byte count often wrong; eight bytes is the shortest
            start_reply(($urandom_range(0, 3) == 0) ? mbrc_pkg::WANT_COUNT
                                                    : 8'($urandom_range(0, 255)));
            add_random_bytes($urandom_range(3, 10));
            emit_frame(CRC_GOOD);
         end else if (kind < 83) begin
            frame_buf.delete();
            add_random_bytes($urandom_range(1, 7));
            emit_frame(CRC_NONE);
         end else if (kind < 90) begin
            // long reply, often past the counter cap
            start_reply(($urandom_range(0, 1) == 0) ? mbrc_pkg::WANT_COUNT
                                                    : 8'($urandom_range(0, 255)));
            add_random_bytes($urandom_range(6, 60));
            emit_frame(CRC_GOOD);
         end else begin
            frame_buf.delete();
            add_random_bytes($urandom_range(1, 30));
            emit_frame(CRC_NONE);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Drive in bursts; hold each word until it is taken.
      idx = 0;
      while (idx < stim_q.size()) begin
         burst = $urandom_range(1, 48);
         while (burst > 0 && idx < stim_q.size()) begin
            req_valid <= 1'b1;
            req_data  <= stim_q[idx];
            do @(posedge clock); while (req_stall);
            idx++;
            words_sent++;
            burst--;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0 && idx < stim_q.size()) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      // Drain: wait for every reply word, then give stray words time to show.
      @(posedge clock);
      while (pending_replies != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_total == 0 && pending_replies == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
